// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL, included by htcl_dp.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- sv/htcl_pkg.sv -----
package htcl_pkg;

    localparam int MAX_DIST = 64;
    localparam int DIST_W   = 7;
    localparam int LIST_AW  = 6;
    localparam int NODE_CNT = 2 * MAX_DIST - 1;
    localparam int NODE_W   = 7;
    localparam int CNT_W    = 16;
    localparam int WT_W     = CNT_W + LIST_AW;
    localparam int TOT_W    = 22;
    localparam int ACC_W    = TOT_W + 1;
    localparam int DEP_W    = 7;
    localparam int PROD_W   = WT_W + DEP_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic upd;
        logic chk;
        logic l1;
        logic l2;
        logic l3;
        logic srd;
        logic scmp;
        logic j1;
        logic j2;
        logic d1;
        logic d2;
        logic d3;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic dist_lt2;
        logic leaf_done;
        logic scan_done;
        logic merge_done;
        logic depth_done;
        logic out_free;
    } t_sts;

endpackage

// ----- sv/huffman_total_code_length.sv -----
// Huffman total code length.
// Input stream s_*: one message byte per item in s_tdata, s_tlast marks the
// final byte. Each byte is read from the count store and then updated
// before the next one is taken. After the final byte the block builds the
// Huffman tree with s_tready low: it loads the leaf weights, then in each
// merge round scans the weight memory node by node for the two lightest
// free nodes, then walks the nodes to find their depths. With fewer than
// two distinct bytes it skips the build.
// Output stream m_*: one result item per message: total bits, distinct
// count and an overflow flag. The result sits in an output register, so the
// next message is taken while it waits; a stalled receiver only holds up
// the block once the next result is ready.
// Reset (synchronous, active low) empties the count store and the output.
module huffman_total_code_length import htcl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [21:0] total_bits, [28:22] distinct_count, rest zero
    output logic        m_tuser    // [0] overflow
);

    t_cmd               cmd;
    t_sts               sts;
    logic [TOT_W-1:0]   total;
    logic [DIST_W-1:0]  dist_cnt;

    htcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htcl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sym       (s_tdata),
        .i_last      (s_tlast),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_total     (total),
        .o_dist      (dist_cnt),
        .o_ovf       (m_tuser)
    );

    assign m_tdata = {3'b000, dist_cnt, total};

endmodule

// ----- sv/htcl_ctrl.sv -----
module htcl_ctrl import htcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_L1   = 4'd3;
    localparam logic [3:0] S_L2   = 4'd4;
    localparam logic [3:0] S_L3   = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SCMP = 4'd7;
    localparam logic [3:0] S_J1   = 4'd8;
    localparam logic [3:0] S_J2   = 4'd9;
    localparam logic [3:0] S_D1   = 4'd10;
    localparam logic [3:0] S_D2   = 4'd11;
    localparam logic [3:0] S_D3   = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Decode commands from the state
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.chk      = (r_state == S_CHK);
        o_cmd.l1       = (r_state == S_L1);
        o_cmd.l2       = (r_state == S_L2);
        o_cmd.l3       = (r_state == S_L3);
        o_cmd.srd      = (r_state == S_SRD);
        o_cmd.scmp     = (r_state == S_SCMP);
        o_cmd.j1       = (r_state == S_J1);
        o_cmd.j2       = (r_state == S_J2);
        o_cmd.d1       = (r_state == S_D1);
        o_cmd.d2       = (r_state == S_D2);
        o_cmd.d3       = (r_state == S_D3);
        o_cmd.out_load = (r_state == S_OUT) && i_sts.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_UPD;
            S_UPD:  n_state = i_sts.last ? S_CHK : S_IDLE;
            S_CHK:  n_state = i_sts.dist_lt2 ? S_OUT : S_L1;
            S_L1:   n_state = S_L2;
            S_L2:   n_state = S_L3;
            S_L3:   n_state = i_sts.leaf_done ? S_SRD : S_L1;
            S_SRD:  n_state = S_SCMP;
            S_SCMP: n_state = i_sts.scan_done ? S_J1 : S_SRD;
            S_J1:   n_state = S_J2;
            S_J2:   n_state = i_sts.merge_done ? S_D1 : S_SRD;
            S_D1:   n_state = S_D2;
            S_D2:   n_state = S_D3;
            S_D3:   n_state = i_sts.depth_done ? S_OUT : S_D1;
            S_OUT:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/htcl_dp.sv -----
`include "assert_macros.svh"

module htcl_dp import htcl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [7:0]        i_sym,
    input  logic              i_last,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [TOT_W-1:0]  o_total,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_ovf
);

    localparam int                SUM_W    = PROD_W + 1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_LIM = DIST_W'(MAX_DIST);
    localparam logic [ACC_W-1:0]  TOT_MAX  = ACC_W'((1 << TOT_W) - 1);

    // Memories
    logic [CNT_W-1:0]   mem_cnt  [256];
    logic [7:0]         mem_list [MAX_DIST];
    logic [WT_W-1:0]    mem_w    [NODE_CNT];
    logic [NODE_W-1:0]  mem_p    [NODE_CNT];
    logic [DEP_W-1:0]   mem_d    [NODE_CNT];

    logic [255:0]          r_cnt_vld;
    logic [CNT_W-1:0]      r_cnt_rd;
    logic                  r_cnt_hit;
    logic [7:0]            r_list_rd;
    logic [WT_W-1:0]       r_w_rd;
    logic [NODE_W-1:0]     r_p_rd;
    logic [DEP_W-1:0]      r_d_rd;
    logic [7:0]            r_sym;
    logic                  r_last;
    logic [DIST_W-1:0]     r_dist;
    logic [CNT_W-1:0]      r_len;
    logic                  r_ovf;
    logic [NODE_CNT-1:0]   r_hp;
    logic [NODE_W-1:0]     r_i;
    logic [NODE_W-1:0]     r_k;
    logic [NODE_W-1:0]     r_j;
    logic [NODE_W-1:0]     r_a;
    logic [NODE_W-1:0]     r_b;
    logic [WT_W-1:0]       r_wa;
    logic [WT_W-1:0]       r_wb;
    logic                  r_ha;
    logic                  r_hb;
    logic [ACC_W-1:0]      r_acc;
    logic                  r_out_vld;
    logic [TOT_W-1:0]      r_out_total;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  r_out_ovf;

    logic [CNT_W-1:0]   cur_cnt;
    logic               is_new;
    logic               full;
    logic               counted;
    logic [7:0]         cnt_addr;
    logic [DEP_W-1:0]   dep_new;
    logic [PROD_W-1:0]  prod;
    logic [SUM_W-1:0]   acc_sum;
    logic [7:0]         root_idx;

    assign cur_cnt  = r_cnt_hit ? r_cnt_rd : '0;
    assign is_new   = (cur_cnt == '0);
    assign full     = (r_dist == DIST_LIM);
    assign counted  = !is_new || !full;
    assign cnt_addr = i_cmd.accept ? i_sym : r_list_rd;
    assign dep_new  = r_d_rd + DEP_W'(1);
    assign prod     = PROD_W'(r_w_rd) * PROD_W'(dep_new);
    assign acc_sum  = SUM_W'(r_acc) + SUM_W'(prod);
    assign root_idx = {r_dist, 1'b0} - 8'd2;

    // Status toward the controller
    always_comb begin
        o_sts.last       = r_last;
        o_sts.dist_lt2   = (r_dist < DIST_W'(2));
        o_sts.leaf_done  = ({1'b0, r_i} + 8'd1) == {1'b0, r_dist};
        o_sts.scan_done  = ({1'b0, r_i} + 8'd1) == {1'b0, r_k};
        o_sts.merge_done = ({1'b0, r_k} == root_idx);
        o_sts.depth_done = (r_j == '0);
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    // Byte count store: read on accept or leaf load, write on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept || i_cmd.l2) begin
            r_cnt_rd  <= mem_cnt[cnt_addr];
            r_cnt_hit <= r_cnt_vld[cnt_addr];
        end
        if (i_cmd.upd && counted && cur_cnt != CNT_MAX) begin
            mem_cnt[r_sym] <= cur_cnt + CNT_W'(1);
        end
    end

    // Distinct list in order of first appearance
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && is_new && !full) begin
            mem_list[r_dist[LIST_AW-1:0]] <= r_sym;
        end
        if (i_cmd.l1) begin
            r_list_rd <= mem_list[r_i[LIST_AW-1:0]];
        end
    end

    // Node weights
    always_ff @(posedge i_clk) begin
        if (i_cmd.l3) begin
            mem_w[r_i] <= WT_W'(cur_cnt);
        end else if (i_cmd.j1) begin
            mem_w[r_k] <= r_wa + r_wb;
        end
        if (i_cmd.srd) begin
            r_w_rd <= mem_w[r_i];
        end else if (i_cmd.d1) begin
            r_w_rd <= mem_w[r_j];
        end
    end

    // Parent links and depths
    always_ff @(posedge i_clk) begin
        if (i_cmd.j1) begin
            mem_p[r_a] <= r_k;
        end else if (i_cmd.j2) begin
            mem_p[r_b] <= r_k;
        end
        if (i_cmd.d1) begin
            r_p_rd <= mem_p[r_j];
        end
        if (i_cmd.j2 && o_sts.merge_done) begin
            mem_d[r_k] <= '0;
        end else if (i_cmd.d3) begin
            mem_d[r_j] <= dep_new;
        end
        if (i_cmd.d2) begin
            r_d_rd <= mem_d[r_p_rd];
        end
    end

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sym  <= i_sym;
            r_last <= i_last;
        end
    end

    // Message state: counts valid, distinct total, length, overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_dist    <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_cnt_vld <= '0;
            r_dist    <= '0;
            r_len     <= '0;
            r_ovf     <= 1'b0;
        end else if (i_cmd.upd) begin
            if (is_new && !full) begin
                r_dist <= r_dist + DIST_W'(1);
            end
            if (counted && cur_cnt != CNT_MAX) begin
                r_cnt_vld[r_sym] <= 1'b1;
            end
            if (r_len != CNT_MAX) begin
                r_len <= r_len + CNT_W'(1);
            end
            if ((is_new && full) || (counted && cur_cnt == CNT_MAX) || r_len == CNT_MAX) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Tree build counters, selection and parent flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_i   <= '0;
            r_k   <= r_dist;
            r_hp  <= '0;
            r_acc <= (r_dist == DIST_W'(1)) ? ACC_W'(r_len) : '0;
        end
        if (i_cmd.l3) begin
            r_i <= o_sts.leaf_done ? '0 : r_i + NODE_W'(1);
        end
        if (i_cmd.srd && r_i == '0) begin
            r_ha <= 1'b0;
            r_hb <= 1'b0;
        end
        if (i_cmd.scmp) begin
            r_i <= r_i + NODE_W'(1);
            if (!r_hp[r_i]) begin
                if (!r_ha || r_w_rd < r_wa) begin
                    r_b  <= r_a;
                    r_wb <= r_wa;
                    r_hb <= r_ha;
                    r_a  <= r_i;
                    r_wa <= r_w_rd;
                    r_ha <= 1'b1;
                end else if (!r_hb || r_w_rd < r_wb) begin
                    r_b  <= r_i;
                    r_wb <= r_w_rd;
                    r_hb <= 1'b1;
                end
            end
        end
        if (i_cmd.j1) begin
            r_hp[r_a] <= 1'b1;
            r_hp[r_b] <= 1'b1;
        end
        if (i_cmd.j2) begin
            r_i <= '0;
            r_k <= r_k + NODE_W'(1);
            if (o_sts.merge_done) begin
                r_j   <= r_k - NODE_W'(1);
                r_acc <= '0;
            end
        end
        if (i_cmd.d3) begin
            r_j <= r_j - NODE_W'(1);
            // Hold the sum just above the largest total once it runs past it
            if ({1'b0, r_j} < {1'b0, r_dist}) begin
                if (acc_sum > SUM_W'(TOT_MAX)) begin
                    r_acc <= TOT_MAX + ACC_W'(1);
                end else begin
                    r_acc <= ACC_W'(acc_sum);
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_total <= (r_acc > TOT_MAX) ? TOT_MAX[TOT_W-1:0] : r_acc[TOT_W-1:0];
            r_out_dist  <= r_dist;
            r_out_ovf   <= r_ovf || (r_acc > TOT_MAX);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_total     = r_out_total;
    assign o_dist      = r_out_dist;
    assign o_ovf       = r_out_ovf;

    `ASSERT_NEVER(a_dist_bound, i_clk, i_rst_n, r_dist > DIST_LIM)
    `ASSERT_PROP(a_clear_after_result, i_clk, i_rst_n, i_cmd.out_load |=> (r_dist == '0 && r_len == '0))
    `ASSERT_PROP(a_two_picked, i_clk, i_rst_n, i_cmd.j1 |-> (r_ha && r_hb && r_a != r_b))

endmodule
